// ===== src/edrj_pkg.sv =====
// Shared constants, tables and beat structures of the exponential-decay fit block.
// No dependencies; used by edrj_exp, edrj_fit and exp_decay_residual_jacobian_top.
package edrj_pkg;

	// fixed-point format
	localparam int FRAC_BITS = 16;
	// quotient bits of |t|/lambda below the exp clamp of 32
	localparam int QB = FRAC_BITS + 5;
	localparam int TAYLOR_TERMS = 14;
	// quotient bits of the slope division below its cap of 2^40
	localparam int SD_QB = 40;

	localparam logic [26:0] LOG2E_Q26 = 27'd96817625;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] E_MAX = 31'h7fff_ffff;

	// configuration register indices
	localparam logic [1:0] REG_AMPLITUDE = 2'd0;
	localparam logic [1:0] REG_DECAY = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	// floor(2^32 / n), used for the series division by n
	localparam logic [32:0] RECIP [1:TAYLOR_TERMS] = '{
		33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
		33'd858993459, 33'd715827882, 33'd613566756, 33'd536870912,
		33'd477218588, 33'd429496729, 33'd390451572, 33'd357913941,
		33'd330382099, 33'd306783378
	};

	// per-point side data carried through the exp pipeline
	typedef struct packed {
		logic last;
		logic t_neg;
		logic t_zero;
		logic clamp;
		logic [31:0] tm;
		logic signed [31:0] y;
	} edrj_tag_t;

	// beat leaving the exp pipeline
	typedef struct packed {
		edrj_tag_t tag;
		logic [30:0] e;
		logic ovf;
	} edrj_etag_t;

	// result beat
	typedef struct packed {
		logic signed [31:0] res;
		logic [30:0] e;
		logic signed [31:0] sd;
		logic ovf;
		logic last;
	} edrj_out_t;

endpackage

// ===== src/exp_decay_residual_jacobian_top.sv =====
// Top level of the exponential-decay fit evaluator: registers, input stage, output buffer.
// Depends on edrj_pkg, edrj_exp and edrj_fit.
//
// Takes points (t, y) and returns the residual A*exp(-t/lambda)+b-y with the
// Jacobian entries exp(-t/lambda) and t/lambda^2*A*exp(-t/lambda), all Q16.16, saturating
// with overflow_flag. The pipeline depth is set by the one-bit-a-stage dividers for
// t/lambda and for the division by lambda^2 and by the 42 stages of the Taylor series.
// Throughput is one point a cycle while the pipeline is not held. A two-beat output
// buffer lets the pipeline keep moving while a result waits; the whole pipeline holds
// only when that buffer is full and the last stage carries a beat. Registers are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no point is in
// flight, which the block does not enforce. A decay_constant of zero acts as one LSB.
module exp_decay_residual_jacobian_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] sample_time,
	input logic signed [31:0] measured_value,
	input logic last_point,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] residual,
	output logic [30:0] slope_amplitude,
	output logic signed [31:0] slope_decay,
	output logic overflow_flag,
	output logic last_out
);

	// configuration registers
	logic signed [31:0] amp_q;
	logic [30:0] lam_q;
	logic signed [31:0] off_q;
	logic [30:0] lam;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= 32'sd1 <<< edrj_pkg::FRAC_BITS;
			lam_q <= 31'd1 << edrj_pkg::FRAC_BITS;
			off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				edrj_pkg::REG_AMPLITUDE: amp_q <= cfg_data;
				edrj_pkg::REG_DECAY: lam_q <= cfg_data[30:0];
				edrj_pkg::REG_OFFSET: off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lam = (lam_q == 31'd0) ? 31'd1 : lam_q;

	// global advance: hold only when the buffer is full and a beat waits to enter it
	logic adv;
	logic fit_v;
	edrj_pkg::edrj_out_t fit_o;
	logic [1:0] cnt_q;

	assign adv = !fit_v || (cnt_q != 2'd2);
	assign in_ready = adv;

	// input stage: magnitude of t and exp clamp test
	logic [31:0] tm;
	assign tm = sample_time[31] ? 32'(~sample_time + 32'sd1) : 32'(sample_time);

	logic v_s1;
	edrj_pkg::edrj_tag_t tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.last <= last_point;
			tag_s1.t_neg <= sample_time[31];
			tag_s1.t_zero <= (sample_time == 32'sd0);
			tag_s1.clamp <= {5'b0, tm} >= {1'b0, lam, 5'b0};
			tag_s1.tm <= tm;
			tag_s1.y <= measured_value;
		end
	end

	logic exp_v;
	edrj_pkg::edrj_etag_t exp_e;

	edrj_exp u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.lam(lam),
		.in_v(v_s1),
		.in_tag(tag_s1),
		.out_v(exp_v),
		.out_e(exp_e)
	);

	edrj_fit u_fit (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.amp(amp_q),
		.off(off_q),
		.lam(lam),
		.in_v(exp_v),
		.in_e(exp_e),
		.out_v(fit_v),
		.out_o(fit_o)
	);

	// two-beat output buffer
	edrj_pkg::edrj_out_t ent0_q;
	edrj_pkg::edrj_out_t ent1_q;
	logic push;
	logic pop;

	assign push = fit_v && adv;
	assign out_valid = (cnt_q != 2'd0);
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) ent0_q <= fit_o;
				else ent1_q <= fit_o;
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent0_q <= fit_o;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= fit_o;
				end
			end
			default: ;
		endcase
	end

	assign residual = ent0_q.res;
	assign slope_amplitude = ent0_q.e;
	assign slope_decay = ent0_q.sd;
	assign overflow_flag = ent0_q.ovf;
	assign last_out = ent0_q.last;

	// full buffer with a waiting beat must hold the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && fit_v) |-> !in_ready)
		else $error("input taken while output buffer full");

	// a held last stage keeps its beat
	assert property (@(posedge clk) disable iff (!arst_n)
		(fit_v && !adv) |=> (fit_v && $stable(fit_o)))
		else $error("pipeline beat lost during hold");

	// buffer count never exceeds two
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2))
		else $error("output buffer overrun");

endmodule

// ===== src/edrj_exp.sv =====
// Pipelined exp(-t/lambda): bit-per-stage divider, base-2 split, Taylor series, scaling.
// Depends on edrj_pkg.
module edrj_exp (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [30:0] lam,
	input logic in_v,
	input edrj_pkg::edrj_tag_t in_tag,
	output logic out_v,
	output edrj_pkg::edrj_etag_t out_e
);

	localparam int F = edrj_pkg::FRAC_BITS;
	localparam int QB = edrj_pkg::QB;
	localparam int DW = F + 37;
	localparam int PW = QB + 29;
	localparam int YW = PW - (F - 4);
	localparam int NT = edrj_pkg::TAYLOR_TERMS;
	localparam int NS = 3 * NT;

	typedef struct packed {
		logic [29:0] x;
		logic [7:0] k;
		logic [31:0] sum;
		logic [30:0] term;
		logic [60:0] prod;
		logic [30:0] v;
		logic [31:0] est;
		edrj_pkg::edrj_tag_t tag;
	} lane_t;

	// divider chain: |t|*2^F / lambda, one quotient bit a stage
	logic [DW-1:0] rem_s [0:QB];
	logic [QB-1:0] qm_s [0:QB];
	edrj_pkg::edrj_tag_t dtag_s [0:QB];
	logic dv_s [0:QB];

	assign rem_s[0] = {5'b0, in_tag.tm, {F{1'b0}}};
	assign qm_s[0] = '0;
	assign dtag_s[0] = in_tag;
	assign dv_s[0] = in_v;

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [DW-1:0] dsh;
		logic ge;
		assign dsh = DW'(lam) << B;
		assign ge = rem_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[j+1] <= 1'b0;
			end else if (en) begin
				dv_s[j+1] <= dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
				qm_s[j+1] <= qm_s[j] | (QB'(ge) << B);
				dtag_s[j+1] <= dtag_s[j];
			end
		end
	end

	// signed exponent times log2(e)
	logic signed [QB:0] q;
	logic signed [PW-1:0] p;
	assign q = dtag_s[QB].t_zero ? '0 :
		(dtag_s[QB].t_neg ? $signed({1'b0, qm_s[QB]}) : -$signed({1'b0, qm_s[QB]}));
	assign p = q * $signed({1'b0, edrj_pkg::LOG2E_Q26});

	logic signed [PW-1:0] p_s1;
	edrj_pkg::edrj_tag_t tg_s1;
	logic ev_s1;

	// split into integer and fraction, scale fraction by ln2
	logic [YW-1:0] y30;
	assign y30 = p_s1[PW-1:F-4];

	logic [7:0] k_s2;
	logic [59:0] xp_s2;
	edrj_pkg::edrj_tag_t tg_s2;
	logic ev_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= 1'b0;
			ev_s2 <= 1'b0;
		end else if (en) begin
			ev_s1 <= dv_s[QB];
			ev_s2 <= ev_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p;
			tg_s1 <= dtag_s[QB];
			k_s2 <= y30[YW-1:30];
			xp_s2 <= 60'(y30[29:0]) * 60'(edrj_pkg::LN2_Q30);
			tg_s2 <= tg_s1;
		end
	end

	// Taylor series of 2^f, three stages a term
	lane_t tl_s [0:NS];
	logic tv_s [0:NS];

	always_comb begin
		tl_s[0] = '0;
		tl_s[0].x = xp_s2[59:30];
		tl_s[0].k = k_s2;
		tl_s[0].sum = 32'(edrj_pkg::ONE_Q30);
		tl_s[0].term = edrj_pkg::ONE_Q30;
		tl_s[0].tag = tg_s2;
	end
	assign tv_s[0] = ev_s2;

	for (genvar n = 1; n <= NT; n++) begin : g_term
		localparam int A = 3 * (n - 1);
		logic [63:0] rm;
		logic [35:0] est_n;
		logic [35:0] r;
		logic [30:0] tnext;
		lane_t nx1;
		lane_t nx2;
		lane_t nx3;

		assign rm = 64'(tl_s[A+1].prod[60:30]) * 64'(edrj_pkg::RECIP[n]);
		assign est_n = 36'(tl_s[A+2].est) * 36'(n);
		assign r = {5'b0, tl_s[A+2].v} - est_n;
		assign tnext = (r >= 36'(n)) ? 31'(tl_s[A+2].est + 32'd1) : tl_s[A+2].est[30:0];

		// next lane contents: product, quotient estimate, corrected term and sum
		always_comb begin
			nx1 = tl_s[A];
			nx1.prod = 61'(tl_s[A].term) * 61'(tl_s[A].x);
			nx2 = tl_s[A+1];
			nx2.v = tl_s[A+1].prod[60:30];
			nx2.est = rm[63:32];
			nx3 = tl_s[A+2];
			nx3.term = tnext;
			nx3.sum = tl_s[A+2].sum + {1'b0, tnext};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tv_s[A+1] <= 1'b0;
				tv_s[A+2] <= 1'b0;
				tv_s[A+3] <= 1'b0;
			end else if (en) begin
				tv_s[A+1] <= tv_s[A];
				tv_s[A+2] <= tv_s[A+1];
				tv_s[A+3] <= tv_s[A+2];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tl_s[A+1] <= nx1;
				tl_s[A+2] <= nx2;
				tl_s[A+3] <= nx3;
			end
		end
	end

	// scale by 2^(k+F-30), rounding half up; clamp and saturate
	logic signed [9:0] sv;
	logic [9:0] rsh;
	logic [72:0] rnd;
	logic [30:0] e_n;
	logic ovf_n;
	lane_t tl;

	assign tl = tl_s[NS];
	assign sv = $signed({{2{tl.k[7]}}, tl.k}) + 10'(F - 30);
	assign rsh = 10'(-sv);
	assign rnd = ({41'd0, tl.sum} + (73'd1 << (rsh[5:0] - 6'd1))) >> rsh[5:0];

	always_comb begin
		e_n = '0;
		ovf_n = 1'b0;
		if (tl.tag.clamp) begin
			if (tl.tag.t_neg) begin
				e_n = edrj_pkg::E_MAX;
				ovf_n = 1'b1;
			end
		end else if (sv > 10'sd0) begin
			e_n = edrj_pkg::E_MAX;
			ovf_n = 1'b1;
		end else if (sv == 10'sd0) begin
			if (tl.sum > 32'(edrj_pkg::E_MAX)) begin
				e_n = edrj_pkg::E_MAX;
				ovf_n = 1'b1;
			end else begin
				e_n = tl.sum[30:0];
			end
		end else if (rsh <= 10'd40) begin
			e_n = rnd[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= tv_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_e.tag <= tl.tag;
			out_e.e <= e_n;
			out_e.ovf <= ovf_n;
		end
	end

endmodule

// ===== src/edrj_fit.sv =====
// Residual and lambda slope: products, saturation and a bit-per-stage rounding divider.
// Depends on edrj_pkg.
module edrj_fit (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic signed [31:0] amp,
	input logic signed [31:0] off,
	input logic [30:0] lam,
	input logic in_v,
	input edrj_pkg::edrj_etag_t in_e,
	output logic out_v,
	output edrj_pkg::edrj_out_t out_o
);

	localparam int F = edrj_pkg::FRAC_BITS;
	localparam int NQ = edrj_pkg::SD_QB;
	localparam int NW = 63 + NQ;

	typedef struct packed {
		logic [30:0] e;
		logic ovf;
		logic last;
		logic neg;
		logic zero;
		logic over;
		logic signed [31:0] res;
	} fl_t;

	localparam logic signed [65:0] RMAX = 66'sd2147483647;
	localparam logic signed [65:0] RMIN = -66'sd2147483648;

	// lambda squared, refreshed every cycle from the register
	logic [61:0] lam_sq_q;
	always_ff @(posedge clk) begin
		lam_sq_q <= 62'(lam) * 62'(lam);
	end

	// stage 1: A*e and |t|*|A|
	logic [31:0] am;
	assign am = amp[31] ? 32'(~amp + 32'sd1) : 32'(amp);

	logic signed [63:0] ae_s1;
	logic [63:0] tmam_s1;
	logic signed [31:0] y_s1;
	fl_t f_s1;
	logic v_s1;

	// stage 2: residual and partial products of |t*A|*e
	logic signed [65:0] mr;
	logic signed [65:0] m;
	logic signed [65:0] rw;
	fl_t f2_n;
	assign mr = 66'(ae_s1) + (66'sd1 <<< (F - 1));
	assign m = mr >>> F;
	assign rw = m + 66'(off) - 66'(y_s1);

	// saturate the residual
	always_comb begin
		f2_n = f_s1;
		if (rw > RMAX) begin
			f2_n.res = 32'sh7fff_ffff;
			f2_n.ovf = 1'b1;
		end else if (rw < RMIN) begin
			f2_n.res = 32'sh8000_0000;
			f2_n.ovf = 1'b1;
		end else begin
			f2_n.res = rw[31:0];
		end
	end

	logic [62:0] p0_s2;
	logic [62:0] p1_s2;
	fl_t f_s2;
	logic v_s2;

	// stage 3: combine partial products
	logic [94:0] n_s3;
	fl_t f_s3;
	logic v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ae_s1 <= amp * $signed({1'b0, in_e.e});
			tmam_s1 <= 64'(in_e.tag.tm) * 64'(am);
			y_s1 <= in_e.tag.y;
			f_s1.e <= in_e.e;
			f_s1.ovf <= in_e.ovf;
			f_s1.last <= in_e.tag.last;
			f_s1.neg <= in_e.tag.t_neg ^ amp[31];
			f_s1.zero <= in_e.tag.t_zero | (amp == 32'sd0) | (in_e.e == 31'd0);
			f_s1.over <= 1'b0;
			f_s1.res <= '0;

			p0_s2 <= 63'(tmam_s1[31:0]) * 63'(f_s1.e);
			p1_s2 <= 63'(tmam_s1[63:32]) * 63'(f_s1.e);
			f_s2 <= f2_n;

			n_s3 <= 95'(p0_s2) + (95'(p1_s2) << 32);
			f_s3 <= f_s2;
		end
	end

	// divider chain: quotient over lambda^2, one bit a stage, cap checked first
	logic [NW-1:0] rem_s [0:NQ];
	logic [NQ-1:0] qq_s [0:NQ];
	fl_t ft_s [0:NQ];
	logic vv_s [0:NQ];
	fl_t f0_n;

	always_comb begin
		f0_n = f_s3;
		f0_n.over = NW'(n_s3) >= (NW'(lam_sq_q) << NQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_s[0] <= 1'b0;
		end else if (en) begin
			vv_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= NW'(n_s3);
			qq_s[0] <= '0;
			ft_s[0] <= f0_n;
		end
	end

	for (genvar j = 0; j < NQ; j++) begin : g_div
		localparam int B = NQ - 1 - j;
		logic [NW-1:0] dsh;
		logic ge;
		assign dsh = NW'(lam_sq_q) << B;
		assign ge = rem_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[j+1] <= 1'b0;
			end else if (en) begin
				vv_s[j+1] <= vv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
				qq_s[j+1] <= qq_s[j] | (NQ'(ge) << B);
				ft_s[j+1] <= ft_s[j];
			end
		end
	end

	// round half up, apply sign and saturate
	fl_t fe;
	logic half;
	logic [40:0] mag;
	logic [40:0] mag_c;
	logic signed [31:0] sd_n;
	logic ovf_n;

	assign fe = ft_s[NQ];
	assign half = {rem_s[NQ][61:0], 1'b0} >= {1'b0, lam_sq_q};
	assign mag = fe.over ? (41'd1 << NQ) : 41'(qq_s[NQ]) + 41'(half);

	always_comb begin
		ovf_n = fe.ovf;
		mag_c = mag;
		sd_n = '0;
		if (!fe.zero) begin
			if (fe.neg) begin
				if (mag > 41'h0_8000_0000) begin
					ovf_n = 1'b1;
					mag_c = 41'h0_8000_0000;
				end
				sd_n = 32'(-mag_c);
			end else begin
				if (mag > 41'h0_7fff_ffff) begin
					ovf_n = 1'b1;
					mag_c = 41'h0_7fff_ffff;
				end
				sd_n = mag_c[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= vv_s[NQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_o.res <= fe.res;
			out_o.e <= fe.e;
			out_o.sd <= sd_n;
			out_o.ovf <= ovf_n;
			out_o.last <= fe.last;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for exp_decay_residual_jacobian_top: drives data points and register
// writes, predicts every result beat and compares it field by field. Depends on edrj_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		logic signed [31:0] t;
		logic signed [31:0] y;
		logic last;
		bit known;
		edrj_pkg::edrj_out_t want;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = edrj_pkg::REG_AMPLITUDE;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] sample_time = '0;
	logic signed [31:0] measured_value = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] residual;
	logic [30:0] slope_amplitude;
	logic signed [31:0] slope_decay;
	logic overflow_flag;
	logic last_out;

	exp_decay_residual_jacobian_top DUT (.*);

	always #5 clk = ~clk;

	// model registers as the block should hold them
	logic signed [31:0] fit_amp = 32'sh0001_0000;
	logic [30:0] fit_lambda = 31'h0001_0000;
	logic signed [31:0] fit_off = '0;

	edrj_pkg::edrj_out_t expected_fits[$];
	int n_errors = 0;
	int n_points = 0;
	int n_results = 0;
	int n_saturated = 0;
	int n_phases = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	// exp(q) in Q16 by base-2 split and Taylor series of the fraction
	function automatic longint exp_q16(longint q, inout bit ovf);
		longint y30, k, s;
		longint unsigned f, x, sum, term;
		int r;
		y30 = (q * 64'sd96817625) >>> (edrj_pkg::FRAC_BITS - 4);
		k = y30 >>> 30;
		f = y30 - (k <<< 30);
		x = (f * 64'd744261118) >> 30;
		sum = 64'd1 << 30;
		term = sum;
		for (int n = 1; n <= edrj_pkg::TAYLOR_TERMS; n++) begin
			term = ((term * x) >> 30) / n;
			sum += term;
		end
		s = k + edrj_pkg::FRAC_BITS - 30;
		if (s > 0) begin
			ovf = 1'b1;
			return SAT_HI;
		end
		if (s == 0) begin
			if (sum > SAT_HI) begin
				ovf = 1'b1;
				return SAT_HI;
			end
			return sum;
		end
		if (-s > 40)
			return 0;
		r = -s;
		return (sum + (64'd1 << (r - 1))) >> r;
	endfunction

	function automatic longint clip32(longint v, inout bit ovf);
		if (v > SAT_HI) begin
			ovf = 1'b1;
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			ovf = 1'b1;
			return SAT_LO;
		end
		return v;
	endfunction

	// residual and Jacobian entries for one point under the current registers
	function automatic edrj_pkg::edrj_out_t fit_point(logic signed [31:0] t,
			logic signed [31:0] y, logic last);
		edrj_pkg::edrj_out_t r;
		longint tt, aa, lam, tm, am, qm, e, m, res, sd;
		logic [127:0] prod, quo, rem, div;
		longint unsigned mag;
		bit ovf;
		ovf = 1'b0;
		tt = t;
		aa = fit_amp;
		lam = (fit_lambda == 0) ? 1 : longint'(fit_lambda);
		tm = (tt < 0) ? -tt : tt;
		am = (aa < 0) ? -aa : aa;
		qm = (tm <<< edrj_pkg::FRAC_BITS) / lam;
		if (qm >= (64'sd32 <<< edrj_pkg::FRAC_BITS)) begin
			if (tt < 0) begin
				e = SAT_HI;
				ovf = 1'b1;
			end else begin
				e = 0;
			end
		end else begin
			e = exp_q16((tt > 0) ? -qm : qm, ovf);
		end
		m = (aa * e + (64'sd1 <<< (edrj_pkg::FRAC_BITS - 1))) >>> edrj_pkg::FRAC_BITS;
		res = clip32(m + longint'(fit_off) - longint'(y), ovf);
		if (tt == 0 || aa == 0 || e == 0) begin
			sd = 0;
		end else begin
			prod = 128'(tm * am) * 128'(e);
			div = 128'(lam * lam);
			quo = prod / div;
			rem = prod % div;
			if (quo >= (128'd1 << 40))
				mag = 64'd1 << 40;
			else
				mag = quo[63:0] + ((2 * rem >= div) ? 1 : 0);
			if ((tt < 0) != (aa < 0)) begin
				if (mag > 64'd2147483648) begin
					ovf = 1'b1;
					mag = 64'd2147483648;
				end
				sd = -longint'(mag);
			end else begin
				if (mag > SAT_HI) begin
					ovf = 1'b1;
					mag = SAT_HI;
				end
				sd = mag;
			end
		end
		r.res = res[31:0];
		r.e = e[30:0];
		r.sd = sd[31:0];
		r.ovf = ovf;
		r.last = last;
		return r;
	endfunction

	// write all three registers on consecutive edges, block idle
	task automatic load_fit_regs(logic signed [31:0] a, logic [30:0] lam, logic signed [31:0] b);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= edrj_pkg::REG_AMPLITUDE;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= edrj_pkg::REG_DECAY;
		cfg_data <= {1'b0, lam};
		@(posedge clk);
		cfg_index <= edrj_pkg::REG_OFFSET;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		fit_amp = a;
		fit_lambda = lam;
		fit_off = b;
	endtask

	// offer one point and hold it until the beat is taken
	task automatic send_point(logic signed [31:0] t, logic signed [31:0] y, logic last,
			bit known, edrj_pkg::edrj_out_t want);
		bit taken;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_time <= t;
		measured_value <= y;
		last_point <= last;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		expected_fits.push_back(known ? want : fit_point(t, y, last));
		n_points++;
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_fits.size() != 0)
			@(posedge clk);
	endtask

	// time value that mostly lands inside the exp range of the current lambda
	function automatic logic signed [31:0] pick_time();
		longint lim;
		logic signed [31:0] v;
		if ($urandom_range(3) == 0)
			return $urandom;
		lim = 32 * ((fit_lambda == 0) ? 1 : longint'(fit_lambda));
		if (lim > SAT_HI)
			lim = SAT_HI;
		v = $urandom_range(0, lim[31:0]);
		return $urandom_range(1) ? -v : v;
	endfunction

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// compare each accepted result beat; watch for a hung pipeline
	always @(negedge clk) begin
		edrj_pkg::edrj_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				quiet_cycles <= 0;
				n_results++;
				if (overflow_flag)
					n_saturated++;
				if (expected_fits.size() == 0) begin
					n_errors++;
					$display("%0t: result beat with nothing expected", $time);
				end else begin
					want = expected_fits.pop_front();
					if (residual !== want.res) begin
						n_errors++;
						$display("%0t: residual exp %h got %h", $time, want.res, residual);
					end
					if (slope_amplitude !== want.e) begin
						n_errors++;
						$display("%0t: slope_amplitude exp %h got %h", $time, want.e,
							slope_amplitude);
					end
					if (slope_decay !== want.sd) begin
						n_errors++;
						$display("%0t: slope_decay exp %h got %h", $time, want.sd, slope_decay);
					end
					if (overflow_flag !== want.ovf) begin
						n_errors++;
						$display("%0t: overflow_flag exp %b got %b", $time, want.ovf,
							overflow_flag);
					end
					if (last_out !== want.last) begin
						n_errors++;
						$display("%0t: last_out exp %b got %b", $time, want.last, last_out);
					end
				end
			end else if (in_valid && in_ready) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		point_row_t rows[$];
		point_row_t row;
		edrj_pkg::edrj_out_t none;
		logic signed [31:0] amp;
		logic [30:0] lam;
		logic signed [31:0] off;

		none = '0;
		// directed points under reset registers; some results read off directly
		rows.push_back('{32'sd0, 32'sd0, 1'b0, 1'b1,
			'{32'sh0001_0000, 31'h0001_0000, 32'sd0, 1'b0, 1'b0}});
		rows.push_back('{32'sh7fff_ffff, 32'sd0, 1'b1, 1'b1,
			'{32'sd0, 31'd0, 32'sd0, 1'b0, 1'b1}});
		rows.push_back('{32'sh8000_0000, 32'sd0, 1'b0, 1'b1,
			'{32'sh7fff_ffff, 31'h7fff_ffff, 32'sh8000_0000, 1'b1, 1'b0}});
		rows.push_back('{32'sd0, 32'sh8000_0000, 1'b1, 1'b1,
			'{32'sh7fff_ffff, 31'h0001_0000, 32'sd0, 1'b1, 1'b1}});
		rows.push_back('{32'sd0, 32'sh7fff_ffff, 1'b0, 1'b0, none});
		rows.push_back('{32'sd1, 32'sd1, 1'b0, 1'b0, none});
		rows.push_back('{-32'sd1, -32'sd1, 1'b1, 1'b0, none});
		rows.push_back('{32'sh0001_0000, 32'sd0, 1'b0, 1'b0, none});
		rows.push_back('{-32'sh0001_0000, 32'sd12345, 1'b0, 1'b0, none});
		rows.push_back('{32'sh001f_ffff, 32'sd0, 1'b0, 1'b0, none});
		rows.push_back('{32'sh0020_0000, 32'sd0, 1'b0, 1'b0, none});
		rows.push_back('{-32'sh001f_ffff, 32'sd0, 1'b0, 1'b0, none});
		rows.push_back('{-32'sh000a_0000, 32'sd0, 1'b0, 1'b0, none});
		rows.push_back('{-32'sh000b_0000, 32'sd0, 1'b0, 1'b0, none});
		rows.push_back('{-32'sh000f_0000, -32'sh7fff_0000, 1'b1, 1'b0, none});
		rows.push_back('{32'sh0004_8000, 32'sh7fff_ffff, 1'b0, 1'b0, none});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			send_point(row.t, row.y, row.last, row.known, row.want);
		end
		drop_valid();

		// random-point phases, each with its own registers and one of four idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			repeat (120) @(posedge clk);
			case (ph)
				0: begin amp = 32'sh8000_0000; lam = 31'd1; off = 32'sh7fff_ffff; end
				1: begin amp = 32'sh7fff_ffff; lam = 31'h7fff_ffff; off = 32'sh8000_0000; end
				2: begin amp = 32'sd0; lam = 31'd0; off = $urandom; end
				3: begin amp = -32'sh0003_0000; lam = 31'h0000_8000; off = 32'sd0; end
				default: begin
					amp = $urandom;
					lam = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 1 << 21));
					off = $urandom;
				end
			endcase
			load_fit_regs(amp, lam, off);
			n_phases++;
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 71; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 71; end
				default: begin idle_pct = 36; stall_pct = 36; end
			endcase
			for (int i = 0; i < 155; i++) begin
				// long receiver hold-off while points keep coming
				if (ph == 4 && i == 10)
					hold_cycles = 400;
				// sender pause until the pipeline has emptied
				if (ph == 5 && i == 80) begin
					drop_valid();
					wait_drained();
				end
				send_point(pick_time(), $urandom, $urandom_range(1), 1'b0, none);
			end
			drop_valid();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_fits.size() != 0) begin
			n_errors++;
			$display("%0t: %0d results never arrived", $time, expected_fits.size());
		end
		$display("Ran %0d points over %0d register settings, %0d results checked.",
			n_points, n_phases + 1, n_results);
		$display("%0d results saturated; idle, stall and hold-off patterns all exercised.",
			n_saturated);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== sim.f =====
src/edrj_pkg.sv
src/edrj_exp.sv
src/edrj_fit.sv
src/exp_decay_residual_jacobian_top.sv
tb/tb_top.sv
